@@ rtl/kcdt_pkg.sv @@
// Shared types and constants for the keyed countdown timer table.
// No dependencies; imported by kcdt_eval and the top-level core.
`default_nettype none

package kcdt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int KIND_W = 2;
  localparam int ID_W   = 16;
  localparam int CNT_W  = 16;
  localparam int STEP_W = 8;
  localparam int ENTRY_W = ID_W + CNT_W;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

  // Per-entry verdict from the shared compare/subtract unit.
  typedef struct packed {
    logic             expired;  // remaining at or below step
    logic             match;    // entry id equals search key
    logic [CNT_W-1:0] dec;      // remaining minus step, valid when not expired
  } entry_eval_t;

endpackage

`default_nettype wire

@@ rtl/keyed_countdown_timer_table_core.sv @@
// Keyed countdown timer table, top level: sequencer walking the entry RAM.
// Depends on kcdt_pkg, kcdt_ram, kcdt_eval.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start / busy         | kind, timer_id, duration, step_size
//  result   | result_valid strobe  | result_kind, result_id, remaining, found,
//           |                      | table_full, last
//
// Start commands never raise busy. Stop, query and tick walk the table once
// through the RAM read port, one entry per cycle, with registered read data
// and a closing step that issues the final result, if any.
// Results leave one per cycle.
// rst is synchronous; the table comes out of reset empty, with no RAM clear.
// Results cannot be stalled; the strobe lasts exactly one cycle.
`default_nettype none

module keyed_countdown_timer_table_core
  import kcdt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [ID_W-1:0]   timer_id,
  input  wire logic [CNT_W-1:0]  duration,
  input  wire logic [STEP_W-1:0] step_size,
  output logic                   result_valid,
  output logic [KIND_W-1:0]      result_kind,
  output logic [ID_W-1:0]        result_id,
  output logic [CNT_W-1:0]       remaining,
  output logic                   found,
  output logic                   table_full,
  output logic                   last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  // control
  logic              state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     rd_idx, rd_idx_next;
  logic [CW-1:0]     wr_idx, wr_idx_next;
  logic              rd_pend, rd_pend_next;
  logic              hit, hit_next;
  logic              pend_valid, pend_valid_next;
  logic              res_valid_next;
  // payload
  logic [KIND_W-1:0] op, op_next;
  logic [ID_W-1:0]   key, key_next;
  logic [STEP_W-1:0] step, step_next;
  logic [CNT_W-1:0]  hit_rem, hit_rem_next;
  logic [ID_W-1:0]   pend_id, pend_id_next;
  logic [KIND_W-1:0] res_kind_next;
  logic [ID_W-1:0]   res_id_next;
  logic [CNT_W-1:0]  res_rem_next;
  logic              res_found_next, res_full_next, res_last_next;

  // RAM port
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_eval_t        eval;
  logic               keep;

  kcdt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  kcdt_eval u_eval (
    .entry_id (ram_rdata[ENTRY_W-1:CNT_W]),
    .entry_rem(ram_rdata[CNT_W-1:0]),
    .key      (key),
    .step     (step),
    .eval     (eval)
  );

  assign busy = (state == S_WALK);

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_idx_next     = rd_idx;
    wr_idx_next     = wr_idx;
    rd_pend_next    = 1'b0;
    hit_next        = hit;
    pend_valid_next = pend_valid;
    op_next         = op;
    key_next        = key;
    step_next       = step;
    hit_rem_next    = hit_rem;
    pend_id_next    = pend_id;
    res_valid_next  = 1'b0;
    res_kind_next   = op;
    res_id_next     = key;
    res_rem_next    = '0;
    res_found_next  = 1'b0;
    res_full_next   = 1'b0;
    res_last_next   = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = wr_idx[AW-1:0];
    ram_wdata       = {ram_rdata[ENTRY_W-1:CNT_W], ram_rdata[CNT_W-1:0]};
    ram_re          = 1'b0;
    ram_raddr       = rd_idx[AW-1:0];
    keep            = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_START) begin
            res_valid_next = 1'b1;
            res_kind_next  = KIND_START;
            res_id_next    = timer_id;
            res_last_next  = 1'b1;
            if (count >= DEPTH_C) begin
              res_full_next = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = count[AW-1:0];
              ram_wdata  = {timer_id, duration};
              count_next = count + 1'b1;
            end
          end else begin
            op_next         = kind;
            key_next        = timer_id;
            step_next       = step_size;
            rd_idx_next     = '0;
            wr_idx_next     = '0;
            hit_next        = 1'b0;
            pend_valid_next = 1'b0;
            state_next      = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (rd_idx < count) begin
          ram_re       = 1'b1;
          rd_idx_next  = rd_idx + 1'b1;
          rd_pend_next = 1'b1;
        end

        if (rd_pend) begin
          // Compaction: for stop and tick, kept entries are rewritten at wr_idx, behind the read.
          priority case (op)
            KIND_TICK: begin
              keep      = !eval.expired;
              ram_wdata = {ram_rdata[ENTRY_W-1:CNT_W], eval.dec};
              if (eval.expired) begin
                // expiry is reported one behind so the final one can carry last
                if (pend_valid) begin
                  res_valid_next = 1'b1;
                  res_kind_next  = KIND_TICK;
                  res_id_next    = pend_id;
                end
                pend_valid_next = 1'b1;
                pend_id_next    = ram_rdata[ENTRY_W-1:CNT_W];
              end
            end
            default: begin
              if (eval.match && !hit) begin
                hit_next     = 1'b1;
                hit_rem_next = ram_rdata[CNT_W-1:0];
                keep         = (op == KIND_QUERY);
              end
            end
          endcase
          if (keep) begin
            ram_we      = (op != KIND_QUERY);
            wr_idx_next = wr_idx + 1'b1;
          end
        end else if (rd_idx == count) begin
          state_next = S_IDLE;
          count_next = wr_idx;
          if (op == KIND_TICK) begin
            res_valid_next = pend_valid;
            res_kind_next  = KIND_TICK;
            res_id_next    = pend_id;
            res_last_next  = 1'b1;
          end else begin
            res_valid_next = 1'b1;
            res_found_next = hit;
            res_rem_next   = hit ? hit_rem : '0;
            res_last_next  = 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rd_idx       <= '0;
      wr_idx       <= '0;
      rd_pend      <= 1'b0;
      hit          <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      rd_idx       <= rd_idx_next;
      wr_idx       <= wr_idx_next;
      rd_pend      <= rd_pend_next;
      hit          <= hit_next;
      pend_valid   <= pend_valid_next;
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    key         <= key_next;
    step        <= step_next;
    hit_rem     <= hit_rem_next;
    pend_id     <= pend_id_next;
    result_kind <= res_kind_next;
    result_id   <= res_id_next;
    remaining   <= res_rem_next;
    found       <= res_found_next;
    table_full  <= res_full_next;
    last        <= res_last_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table depth");

  a_write_behind_read: assert property (@(posedge clk) disable iff (rst)
    wr_idx <= rd_idx)
    else $error("compaction write index passed read index");

  a_pend_only_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == S_WALK)
    else $error("read data pending outside a walk");

  a_walk_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind != KIND_START) |=> busy)
    else $error("table walk command did not raise busy");

  a_walk_ends_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && state_next == S_IDLE && op != KIND_TICK) |=>
      (result_valid && last))
    else $error("stop or query walk ended without a final answer");

endmodule

`default_nettype wire

@@ rtl/kcdt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kcdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/kcdt_eval.sv @@
// Shared compare/subtract unit: judges one table entry per cycle.
// Depends on kcdt_pkg.
`default_nettype none

module kcdt_eval
  import kcdt_pkg::*;
(
  input  wire logic [ID_W-1:0]   entry_id,
  input  wire logic [CNT_W-1:0]  entry_rem,
  input  wire logic [ID_W-1:0]   key,
  input  wire logic [STEP_W-1:0] step,
  output entry_eval_t            eval
);

  logic [CNT_W:0] diff;

  // One subtractor: borrow or zero result means the timer runs out.
  assign diff = {1'b0, entry_rem} - {{(CNT_W + 1 - STEP_W){1'b0}}, step};

  always_comb begin
    eval.expired = diff[CNT_W] || (diff[CNT_W-1:0] == '0);
    eval.match   = (entry_id == key);
    eval.dec     = diff[CNT_W-1:0];
  end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for keyed_countdown_timer_table_core: start, stop,
// query and tick commands against an in-bench model of the timer table.
// Depends on kcdt_pkg and the RTL of the block; reads no files.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kcdt_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } timer_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  rem;
    logic              found;
    logic              full;
    logic              last;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] kind = KIND_START;
  logic [ID_W-1:0]   timer_id = '0;
  logic [CNT_W-1:0]  duration = '0;
  logic [STEP_W-1:0] step_size = '0;
  logic              result_valid;
  logic [KIND_W-1:0] result_kind;
  logic [ID_W-1:0]   result_id;
  logic [CNT_W-1:0]  remaining;
  logic              found;
  logic              table_full;
  logic              last;

  timer_entry_t  timer_table[$];
  timer_result_t pending_results[$];
  int            mismatch_count = 0;
  int            sender_idle_pct = 0;

  keyed_countdown_timer_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .timer_id    (timer_id),
    .duration    (duration),
    .step_size   (step_size),
    .result_valid(result_valid),
    .result_kind (result_kind),
    .result_id   (result_id),
    .remaining   (remaining),
    .found       (found),
    .table_full  (table_full),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void queue_expected(timer_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Table model: updates timer_table and queues the results one command causes.
  function automatic void predict_timer_command(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                                logic [CNT_W-1:0] dur,
                                                logic [STEP_W-1:0] step);
    timer_result_t res;
    timer_entry_t  ent;
    int            pos;
    int            i;
    int            n;
    res = '0;
    res.kind = k;
    res.id = id;
    res.last = 1'b1;
    pos = -1;
    n = 0;
    case (k)
      KIND_START: begin
        if (timer_table.size() >= TABLE_DEPTH) begin
          res.full = 1'b1;
        end else begin
          ent.id = id;
          ent.count = dur;
          timer_table.insert(timer_table.size(), ent);
        end
        queue_expected(res);
      end
      KIND_STOP, KIND_QUERY: begin
        // earliest matching entry wins on duplicate ids
        for (i = 0; i < timer_table.size(); i++) begin
          if (pos < 0 && timer_table[i].id == id) pos = i;
        end
        if (pos >= 0) begin
          res.rem = timer_table[pos].count;
          res.found = 1'b1;
          if (k == KIND_STOP) timer_table.delete(pos);
        end
        queue_expected(res);
      end
      default: begin
        // tick: expire at or below step, no wrap; index holds after a removal
        res.last = 1'b0;
        i = 0;
        while (i < timer_table.size()) begin
          ent = timer_table[i];
          if (ent.count <= step) begin
            res.id = ent.id;
            queue_expected(res);
            timer_table.delete(i);
            n++;
          end else begin
            ent.count = ent.count - step;
            timer_table[i] = ent;
            i++;
          end
        end
        if (n > 0) begin
          res = pending_results[pending_results.size()-1];
          res.last = 1'b1;
          pending_results[pending_results.size()-1] = res;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 60) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    timer_result_t exp_res;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %h", result_kind, result_id));
      end else begin
        exp_res = pending_results.pop_front();
        if (result_kind !== exp_res.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d", result_kind, exp_res.kind));
        if (result_id !== exp_res.id)
          report_mismatch($sformatf("result_id %h, expected %h", result_id, exp_res.id));
        if (remaining !== exp_res.rem)
          report_mismatch($sformatf("remaining %0d, expected %0d (id %h)", remaining,
                                    exp_res.rem, exp_res.id));
        if (found !== exp_res.found)
          report_mismatch($sformatf("found %b, expected %b (id %h)", found, exp_res.found,
                                    exp_res.id));
        if (table_full !== exp_res.full)
          report_mismatch($sformatf("table_full %b, expected %b (id %h)", table_full,
                                    exp_res.full, exp_res.id));
        if (last !== exp_res.last)
          report_mismatch($sformatf("last %b, expected %b (id %h)", last, exp_res.last,
                                    exp_res.id));
      end
    end
  end

  // Drives one command and returns once the transaction is accepted.
  // start stays high afterwards so back-to-back commands need no gap.
  task automatic issue_command(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                               logic [CNT_W-1:0] dur, logic [STEP_W-1:0] step);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    timer_id <= id;
    duration <= dur;
    step_size <= step;
    do @(posedge clk); while (busy !== 1'b0);
    predict_timer_command(k, id, dur, step);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    issue_command(KIND_QUERY, 16'h1234, 16'hFFFF, 8'hFF);
    issue_command(KIND_STOP, 16'hFFFF, 16'h0000, 8'h00);
    issue_command(KIND_TICK, 16'h0000, 16'h0000, 8'h00);
  endtask

  task automatic test_fill_and_reject();
    int i;
    issue_command(KIND_START, 16'h0000, 16'h0000, 8'h00);
    issue_command(KIND_START, 16'hFFFF, 16'hFFFF, 8'hFF);
    issue_command(KIND_START, 16'h5A5A, 16'd1, 8'h00);
    issue_command(KIND_START, 16'h5A5A, 16'd200, 8'h00);
    issue_command(KIND_START, 16'hA5A5, 16'd255, 8'h00);
    issue_command(KIND_START, 16'h0001, 16'd256, 8'h00);
    issue_command(KIND_START, 16'h8000, 16'h8000, 8'h00);
    issue_command(KIND_START, 16'h7FFF, 16'h7FFF, 8'h00);
    for (i = 8; i < TABLE_DEPTH; i++)
      issue_command(KIND_START, 16'h0100 + 16'(i), 16'(i * 300), 8'h00);
    issue_command(KIND_START, 16'h0BAD, 16'h1111, 8'h55);
  endtask

  task automatic test_duplicate_ids();
    issue_command(KIND_QUERY, 16'h5A5A, 16'h0000, 8'h00);
    issue_command(KIND_STOP, 16'h5A5A, 16'h0000, 8'h00);
  endtask

  task automatic test_tick_expiry();
    // zero count with zero step, then adjacent expiries, then exact hit
    issue_command(KIND_TICK, 16'h0000, 16'h0000, 8'd0);
    issue_command(KIND_TICK, 16'h0000, 16'h0000, 8'd255);
    issue_command(KIND_TICK, 16'h0000, 16'h0000, 8'd1);
  endtask

  function automatic logic [ID_W-1:0] pick_timer_id();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    if (r < 24) return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
    if (r < 75) return 16'h0100 + 16'($urandom_range(TABLE_DEPTH - 1));
    return ID_W'($urandom);
  endfunction

  function automatic logic [CNT_W-1:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    if (r < 25) return CNT_W'($urandom);
    return CNT_W'($urandom_range(700, 1));
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return '1;
    return STEP_W'($urandom_range(255));
  endfunction

  task automatic test_random_traffic(int n_items, int idle_pct);
    int                i;
    int                r;
    logic [KIND_W-1:0] k;
    sender_idle_pct = idle_pct;
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 38) k = KIND_START;
      else if (r < 53) k = KIND_STOP;
      else if (r < 68) k = KIND_QUERY;
      else k = KIND_TICK;
      issue_command(k, pick_timer_id(), pick_duration(), pick_step());
      if (i == n_items / 2) wait_results_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sender_idle_pct = 31;
    test_empty_table();
    test_fill_and_reject();
    test_duplicate_ids();
    test_tick_expiry();
    wait_results_drained();
    test_random_traffic(52, 31);
    test_random_traffic(52, 63);
    test_random_traffic(52, 0);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kcdt_pkg.sv
rtl/kcdt_ram.sv
rtl/kcdt_eval.sv
rtl/keyed_countdown_timer_table_core.sv
sim/tb_top.sv
